/* src/layer_tile_work_item_decoder_assert.svh */
// Assertion macros shared by the checker of the layer tile work item decoder.
// Depends on nothing; expects clk_i and rst_ni in the scope of each use.
`ifndef LAYER_TILE_WORK_ITEM_DECODER_ASSERT_SVH
`define LAYER_TILE_WORK_ITEM_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LTWID_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("layer tile decoder check failed");

// Next-cycle implication.
`define LTWID_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("layer tile decoder check failed");

`endif

/* src/ltwid_pkg.sv */
// Package of the layer tile work item decoder: constants, codes and the
// structs passed between stages. Depends on nothing.
`default_nettype none

package ltwid_pkg;

  localparam int TILE_TOKENS    = 512;
  localparam int TILE_SHIFT     = $clog2(TILE_TOKENS);
  localparam int MAX_TOKENS     = 32768;
  localparam int LAYER_COUNT    = 48;
  localparam int HIDDEN_BUFFERS = 2;
  localparam int FULL_PERIOD    = 4;

  localparam int ORD_W    = 12;
  localparam int TOK_W    = 16;
  localparam int TILES_W  = 7;   // tile count, 1..64
  localparam int LAYER_W  = 6;
  localparam int TILE_W   = 6;
  localparam int POS_W    = 15;
  localparam int COUNT_W  = 10;
  localparam int TOTAL_W  = 12;
  localparam int ERR_W    = 3;

  // Restoring divider: quotient is the layer, remainder the tile.
  localparam int QUO_W              = LAYER_W;
  localparam int REM_W              = ORD_W + 1;
  localparam int DIV_STAGES         = 3;
  localparam int DIV_STEPS_PER_STAGE = QUO_W / DIV_STAGES;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK             = 3'd0,
    ERR_BUILD_DISABLED = 3'd1,
    ERR_PROMPT_ZERO    = 3'd2,
    ERR_CAPACITY       = 3'd3,
    ERR_ORDINAL        = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    REG_BUILD_ENABLED   = 2'd0,
    REG_PROMPT_TOKENS   = 2'd1,
    REG_HIDDEN_CAPACITY = 2'd2
  } reg_e;

  typedef struct packed {
    logic             build_enabled;
    logic [TOK_W-1:0] prompt_tokens;
    logic [TOK_W-1:0] hidden_capacity;
  } cfg_t;

  typedef struct packed {
    err_e               err;
    logic [REM_W-1:0]   rem;
    logic [REM_W-1:0]   dvs;
    logic [QUO_W-1:0]   quo;
    logic [TILES_W-1:0] tiles;
    logic [TOTAL_W-1:0] total;
  } pipe_t;

  typedef struct packed {
    logic               item_valid;
    err_e               error_code;
    logic [LAYER_W-1:0] layer_num;
    logic [TILE_W-1:0]  tile_num;
    logic [POS_W-1:0]   start_pos;
    logic [COUNT_W-1:0] tile_len;
    logic               input_buffer;
    logic               output_buffer;
    logic               first_tile;
    logic               last_tile;
    logic               full_attention;
    logic [TOTAL_W-1:0] total_items;
  } res_t;

endpackage

`default_nettype wire

/* src/ltwid_cfg.sv */
// Configuration registers of the layer tile work item decoder on an APB-style port.
// Depends on ltwid_pkg.
`default_nettype none

module ltwid_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ltwid_pkg::ADDR_W-1:0] paddr,
  input  logic [ltwid_pkg::DATA_W-1:0] pwdata,
  output logic [ltwid_pkg::DATA_W-1:0] prdata,
  output ltwid_pkg::cfg_t           cfg_o
);

  ltwid_pkg::cfg_t  cfg_q, cfg_d;
  ltwid_pkg::reg_e  sel;
  logic             wr_en;

  assign sel   = ltwid_pkg::reg_e'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        ltwid_pkg::REG_BUILD_ENABLED:   cfg_d.build_enabled   = pwdata[0];
        ltwid_pkg::REG_PROMPT_TOKENS:   cfg_d.prompt_tokens   = pwdata[ltwid_pkg::TOK_W-1:0];
        ltwid_pkg::REG_HIDDEN_CAPACITY: cfg_d.hidden_capacity = pwdata[ltwid_pkg::TOK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      ltwid_pkg::REG_BUILD_ENABLED:
        prdata = ltwid_pkg::DATA_W'(cfg_q.build_enabled);
      ltwid_pkg::REG_PROMPT_TOKENS:
        prdata = ltwid_pkg::DATA_W'(cfg_q.prompt_tokens);
      ltwid_pkg::REG_HIDDEN_CAPACITY:
        prdata = ltwid_pkg::DATA_W'(cfg_q.hidden_capacity);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.build_enabled   <= 1'b1;
      cfg_q.prompt_tokens   <= '0;
      cfg_q.hidden_capacity <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* src/ltwid_front.sv */
// Entry stage: checks the configuration, derives tile and item counts and
// loads the divider. Depends on ltwid_pkg.
`default_nettype none

module ltwid_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [ltwid_pkg::ORD_W-1:0] ordinal_i,
  input  ltwid_pkg::cfg_t             cfg_i,
  output logic                        valid_o,
  output ltwid_pkg::pipe_t            data_o
);

  logic                          valid_q;
  ltwid_pkg::pipe_t              data_q, data_d;
  logic [ltwid_pkg::TOK_W-1:0]   p_m1;
  logic [ltwid_pkg::TILES_W-1:0] tiles;
  logic [ltwid_pkg::TOTAL_W-1:0] total;
  logic                          cap_bad;

  assign p_m1    = cfg_i.prompt_tokens - ltwid_pkg::TOK_W'(1);
  assign tiles   = ltwid_pkg::TILES_W'(p_m1 >> ltwid_pkg::TILE_SHIFT) +
                   ltwid_pkg::TILES_W'(1);
  assign total   = ltwid_pkg::TOTAL_W'(32'(tiles) * ltwid_pkg::LAYER_COUNT);
  assign cap_bad = (32'(cfg_i.prompt_tokens) > 32'(ltwid_pkg::MAX_TOKENS)) ||
                   (cfg_i.hidden_capacity < cfg_i.prompt_tokens) ||
                   (32'(cfg_i.hidden_capacity) > 32'(ltwid_pkg::MAX_TOKENS));

  always_comb begin
    data_d.tiles = tiles;
    data_d.total = total;
    data_d.rem   = ltwid_pkg::REM_W'(ordinal_i);
    data_d.dvs   = ltwid_pkg::REM_W'(tiles) << (ltwid_pkg::QUO_W - 1);
    data_d.quo   = '0;
    if (!cfg_i.build_enabled) begin
      data_d.err   = ltwid_pkg::ERR_BUILD_DISABLED;
      data_d.total = '0;
    end else if (cfg_i.prompt_tokens == '0) begin
      data_d.err   = ltwid_pkg::ERR_PROMPT_ZERO;
      data_d.total = '0;
    end else if (cap_bad) begin
      data_d.err   = ltwid_pkg::ERR_CAPACITY;
      data_d.total = '0;
    end else if (ordinal_i >= total) begin
      data_d.err   = ltwid_pkg::ERR_ORDINAL;
    end else begin
      data_d.err   = ltwid_pkg::ERR_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* src/ltwid_div_stage.sv */
// One stage of the restoring divider: a fixed number of quotient bits per
// stage, divisor shifted right after each. Depends on ltwid_pkg.
`default_nettype none

module ltwid_div_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  ltwid_pkg::pipe_t data_i,
  output logic             valid_o,
  output ltwid_pkg::pipe_t data_o
);

  logic                          valid_q;
  ltwid_pkg::pipe_t              data_q, data_d;
  logic [ltwid_pkg::REM_W-1:0]   rem;
  logic [ltwid_pkg::REM_W-1:0]   dvs;
  logic [ltwid_pkg::QUO_W-1:0]   quo;

  always_comb begin
    rem = data_i.rem;
    dvs = data_i.dvs;
    quo = data_i.quo;
    for (int s = 0; s < ltwid_pkg::DIV_STEPS_PER_STAGE; s++) begin
      if (rem >= dvs) begin
        rem = rem - dvs;
        quo = {quo[ltwid_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quo = {quo[ltwid_pkg::QUO_W-2:0], 1'b0};
      end
      dvs = dvs >> 1;
    end
    data_d     = data_i;
    data_d.rem = rem;
    data_d.dvs = dvs;
    data_d.quo = quo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* src/ltwid_back.sv */
// Exit stage: builds the descriptor from layer and tile and registers the
// result beat. Depends on ltwid_pkg.
`default_nettype none

module ltwid_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  ltwid_pkg::pipe_t            data_i,
  input  logic [ltwid_pkg::TOK_W-1:0] prompt_tokens_i,
  output logic                        done_o,
  output ltwid_pkg::res_t             res_o
);

  logic                          done_q;
  ltwid_pkg::res_t               res_q, res_d;
  logic [ltwid_pkg::TILE_W-1:0]  tile;
  logic [ltwid_pkg::LAYER_W:0]   layer_p1;
  logic [ltwid_pkg::POS_W-1:0]   first;
  logic [ltwid_pkg::TOK_W-1:0]   left;

  assign tile     = data_i.rem[ltwid_pkg::TILE_W-1:0];
  assign layer_p1 = {1'b0, data_i.quo} + (ltwid_pkg::LAYER_W + 1)'(1);
  assign first    = ltwid_pkg::POS_W'(tile) << ltwid_pkg::TILE_SHIFT;
  assign left     = prompt_tokens_i - ltwid_pkg::TOK_W'(first);

  always_comb begin
    res_d             = '0;
    res_d.error_code  = data_i.err;
    res_d.total_items = data_i.total;
    if (data_i.err == ltwid_pkg::ERR_OK) begin
      res_d.item_valid     = 1'b1;
      res_d.layer_num      = data_i.quo;
      res_d.tile_num       = tile;
      res_d.start_pos      = first;
      res_d.tile_len       = (32'(left) < ltwid_pkg::TILE_TOKENS) ?
                             ltwid_pkg::COUNT_W'(left) :
                             ltwid_pkg::COUNT_W'(ltwid_pkg::TILE_TOKENS);
      res_d.input_buffer   = 1'(data_i.quo % ltwid_pkg::HIDDEN_BUFFERS);
      res_d.output_buffer  = 1'(layer_p1 % ltwid_pkg::HIDDEN_BUFFERS);
      res_d.first_tile     = (tile == '0);
      res_d.last_tile      = (ltwid_pkg::TILES_W'(tile) + ltwid_pkg::TILES_W'(1)) ==
                             data_i.tiles;
      res_d.full_attention = ((layer_p1 % ltwid_pkg::FULL_PERIOD) == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

/* src/layer_tile_work_item_decoder.sv */
// Top level of the layer tile work item decoder: config port, entry stage,
// three divider stages and exit stage. Depends on ltwid_pkg and the ltwid_* modules.
`default_nettype none

// Decodes a work-item ordinal of a layer-major prefill pass into its tile
// descriptor (layer, tile, first token position, clipped token count,
// ping-pong buffer indices, first/last tile and full-attention flags, item
// count). An ordinal is taken on every clock edge where start is high; busy
// is always low, so a new beat can follow in every cycle. Each beat gives one
// result, shown for one cycle with done_o; the receiver cannot stall and must
// take it then. The beat passes one entry stage that checks the configuration
// and counts tiles, three stages of a restoring divider (two quotient bits
// each) that split the ordinal into layer and tile, and one exit stage that
// builds and holds the descriptor. Configuration errors and out-of-range
// ordinals still give a result, with item_valid_o low and error_code_o set.
// Write the registers only while no beat is in flight; registers are at byte
// addresses 0 (build_enabled), 4 (prompt_tokens) and 8 (hidden_capacity).

module layer_tile_work_item_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [ltwid_pkg::ORD_W-1:0]    ordinal_i,
  // result channel
  output logic                           done_o,
  output logic                           item_valid_o,
  output logic [ltwid_pkg::ERR_W-1:0]    error_code_o,
  output logic [ltwid_pkg::LAYER_W-1:0]  layer_num_o,
  output logic [ltwid_pkg::TILE_W-1:0]   tile_num_o,
  output logic [ltwid_pkg::POS_W-1:0]    start_pos_o,
  output logic [ltwid_pkg::COUNT_W-1:0]  tile_len_o,
  output logic                           input_buffer_o,
  output logic                           output_buffer_o,
  output logic                           first_tile_o,
  output logic                           last_tile_o,
  output logic                           full_attention_o,
  output logic [ltwid_pkg::TOTAL_W-1:0]  total_items_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ltwid_pkg::ADDR_W-1:0]   paddr,
  input  logic [ltwid_pkg::DATA_W-1:0]   pwdata,
  output logic [ltwid_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);

  ltwid_pkg::cfg_t  cfg;
  ltwid_pkg::res_t  res;
  logic             stg_valid [ltwid_pkg::DIV_STAGES+1];
  ltwid_pkg::pipe_t stg_data  [ltwid_pkg::DIV_STAGES+1];

  // Every stage advances each cycle; nothing can hold the pipeline.
  assign busy   = 1'b0;
  assign pready = 1'b1;

  ltwid_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // Check configuration, count tiles and items, load the divider.
  ltwid_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start && !busy),
    .ordinal_i (ordinal_i),
    .cfg_i     (cfg),
    .valid_o   (stg_valid[0]),
    .data_o    (stg_data[0])
  );

  // Divide the ordinal by the tile count, two quotient bits per stage.
  for (genvar g = 0; g < ltwid_pkg::DIV_STAGES; g++) begin : g_div
    ltwid_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .data_i  (stg_data[g]),
      .valid_o (stg_valid[g+1]),
      .data_o  (stg_data[g+1])
    );
  end

  // Build the descriptor and drive the result beat.
  ltwid_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (stg_valid[ltwid_pkg::DIV_STAGES]),
    .data_i          (stg_data[ltwid_pkg::DIV_STAGES]),
    .prompt_tokens_i (cfg.prompt_tokens),
    .done_o          (done_o),
    .res_o           (res)
  );

  assign item_valid_o     = res.item_valid;
  assign error_code_o     = res.error_code;
  assign layer_num_o      = res.layer_num;
  assign tile_num_o       = res.tile_num;
  assign start_pos_o      = res.start_pos;
  assign tile_len_o       = res.tile_len;
  assign input_buffer_o   = res.input_buffer;
  assign output_buffer_o  = res.output_buffer;
  assign first_tile_o     = res.first_tile;
  assign last_tile_o      = res.last_tile;
  assign full_attention_o = res.full_attention;
  assign total_items_o    = res.total_items;

endmodule

`default_nettype wire

/* src/ltwid_checker.sv */
// Port-level checks of the layer tile work item decoder and their bind.
// Depends on ltwid_pkg and layer_tile_work_item_decoder_assert.svh.
`default_nettype none

`include "layer_tile_work_item_decoder_assert.svh"

module ltwid_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           done_o,
  input logic                           item_valid_o,
  input logic [ltwid_pkg::ERR_W-1:0]    error_code_o,
  input logic [ltwid_pkg::LAYER_W-1:0]  layer_num_o,
  input logic [ltwid_pkg::TILE_W-1:0]   tile_num_o,
  input logic [ltwid_pkg::POS_W-1:0]    start_pos_o,
  input logic [ltwid_pkg::COUNT_W-1:0]  tile_len_o,
  input logic                           last_tile_o,
  input logic                           full_attention_o
);

  // Each accepted beat comes out with done_o, and nothing else does.
  `LTWID_ASSERT_IMP(a_latency, start && !busy, ##5 done_o)
  `LTWID_ASSERT_IMP(a_no_spurious, !(start && !busy), ##5 !done_o)

  // A valid descriptor carries no error, and only the tail tile is short.
  `LTWID_ASSERT_IMP(a_valid_ok, done_o && item_valid_o,
                    error_code_o == ltwid_pkg::ERR_OK && tile_len_o != '0 &&
                    (last_tile_o || tile_len_o == ltwid_pkg::COUNT_W'(ltwid_pkg::TILE_TOKENS)))

  // A rejected item carries an error and a zeroed descriptor.
  `LTWID_ASSERT_IMP(a_error_zero, done_o && !item_valid_o,
                    error_code_o != ltwid_pkg::ERR_OK && layer_num_o == '0 &&
                    tile_num_o == '0 && start_pos_o == '0 &&
                    tile_len_o == '0 && !full_attention_o)

endmodule

bind layer_tile_work_item_decoder ltwid_checker u_ltwid_checker (.*);

`default_nettype wire

/* tb/layer_tile_work_item_decoder_test.sv */
// Self-checking testbench for layer_tile_work_item_decoder: drives ordinals and
// APB register writes, predicts each descriptor and checks every done_o beat.
// Depends on ltwid_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module layer_tile_work_item_decoder_test;
  import ltwid_pkg::*;

  // Ordinal in, descriptor out through the pipeline; no backpressure on results.
  localparam int PIPE_LATENCY = 5;
  localparam int BURSTS       = 19;
  localparam int BURST_BEATS  = 100;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [ORD_W-1:0]    ordinal_i = '0;
  logic                done_o;
  logic                item_valid_o;
  logic [ERR_W-1:0]    error_code_o;
  logic [LAYER_W-1:0]  layer_num_o;
  logic [TILE_W-1:0]   tile_num_o;
  logic [POS_W-1:0]    start_pos_o;
  logic [COUNT_W-1:0]  tile_len_o;
  logic                input_buffer_o;
  logic                output_buffer_o;
  logic                first_tile_o;
  logic                last_tile_o;
  logic                full_attention_o;
  logic [TOTAL_W-1:0]  total_items_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  layer_tile_work_item_decoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .ordinal_i        (ordinal_i),
    .done_o           (done_o),
    .item_valid_o     (item_valid_o),
    .error_code_o     (error_code_o),
    .layer_num_o      (layer_num_o),
    .tile_num_o       (tile_num_o),
    .start_pos_o      (start_pos_o),
    .tile_len_o       (tile_len_o),
    .input_buffer_o   (input_buffer_o),
    .output_buffer_o  (output_buffer_o),
    .first_tile_o     (first_tile_o),
    .last_tile_o      (last_tile_o),
    .full_attention_o (full_attention_o),
    .total_items_o    (total_items_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the three registers, reset values as the block has them.
  logic             cfg_build = 1'b1;
  logic [TOK_W-1:0] cfg_prompt = '0;
  logic [TOK_W-1:0] cfg_capacity = '0;

  res_t        pending_descriptors[$];
  int unsigned sender_idle_pct = 0;
  int unsigned beats_sent = 0;
  int unsigned descriptors_ok = 0;
  int unsigned descriptors_err = 0;
  int unsigned settings_used = 0;
  int unsigned mismatch_count = 0;

  // Work out the descriptor for one ordinal under the current register values.
  function automatic res_t decode_work_item(input logic [ORD_W-1:0] ord);
    res_t        d;
    int unsigned tiles;
    int unsigned total;
    int unsigned layer;
    int unsigned tile;
    int unsigned first;
    int unsigned left;
    d = '0;
    if (!cfg_build) begin
      d.error_code = ERR_BUILD_DISABLED;
    end else if (cfg_prompt == 0) begin
      d.error_code = ERR_PROMPT_ZERO;
    end else if (cfg_prompt > MAX_TOKENS || cfg_capacity < cfg_prompt ||
                 cfg_capacity > MAX_TOKENS) begin
      d.error_code = ERR_CAPACITY;
    end else begin
      // Round the prompt up to whole tiles; ordinals walk every tile of a layer.
      tiles = 1 + (int'(cfg_prompt) - 1) / TILE_TOKENS;
      total = tiles * LAYER_COUNT;
      d.total_items = TOTAL_W'(total);
      if (ord >= total) begin
        d.error_code = ERR_ORDINAL;
      end else begin
        layer = ord / tiles;
        tile  = ord % tiles;
        first = tile * TILE_TOKENS;
        left  = int'(cfg_prompt) - first;
        d.item_valid     = 1'b1;
        d.layer_num      = LAYER_W'(layer);
        d.tile_num       = TILE_W'(tile);
        d.start_pos      = POS_W'(first);
        // Clip the tail tile to what is left of the prompt.
        d.tile_len       = COUNT_W'((left < TILE_TOKENS) ? left : TILE_TOKENS);
        d.input_buffer   = 1'((layer % HIDDEN_BUFFERS) & 1);
        d.output_buffer  = 1'(((layer + 1) % HIDDEN_BUFFERS) & 1);
        d.first_tile     = (tile == 0);
        d.last_tile      = (tile + 1 == tiles);
        d.full_attention = ((layer + 1) % FULL_PERIOD == 0);
      end
    end
    return d;
  endfunction

  function automatic bit check_field(input string name, input int unsigned want,
                                     input int unsigned got);
    if (want == got) return 1'b0;
    if (mismatch_count < 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
    return 1'b1;
  endfunction

  // Checker: every done_o beat must match the oldest outstanding descriptor.
  always @(posedge clk_i) begin
    res_t want;
    bit   bad;
    if (rst_ni && done_o) begin
      if (pending_descriptors.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: descriptor beat with nothing outstanding", $realtime);
        mismatch_count++;
      end else begin
        want = pending_descriptors.pop_front();
        bad = 1'b0;
        bad |= check_field("item_valid", want.item_valid, item_valid_o);
        bad |= check_field("error_code", want.error_code, error_code_o);
        bad |= check_field("layer_num", want.layer_num, layer_num_o);
        bad |= check_field("tile_num", want.tile_num, tile_num_o);
        bad |= check_field("start_pos", want.start_pos, start_pos_o);
        bad |= check_field("tile_len", want.tile_len, tile_len_o);
        bad |= check_field("input_buffer", want.input_buffer, input_buffer_o);
        bad |= check_field("output_buffer", want.output_buffer, output_buffer_o);
        bad |= check_field("first_tile", want.first_tile, first_tile_o);
        bad |= check_field("last_tile", want.last_tile, last_tile_o);
        bad |= check_field("full_attention", want.full_attention, full_attention_o);
        bad |= check_field("total_items", want.total_items, total_items_o);
        if (bad) mismatch_count++;
        if (want.item_valid) descriptors_ok++;
        else descriptors_err++;
      end
    end
  end

  // Send one ordinal beat; hold start high into the next call unless a gap
  // is drawn, in which case drop start and put noise on the idle bus.
  task automatic send_ordinal(input logic [ORD_W-1:0] ord);
    int unsigned gap;
    @(negedge clk_i);
    start     <= 1'b1;
    ordinal_i <= ord;
    do @(posedge clk_i); while (busy);
    pending_descriptors.push_back(decode_work_item(ord));
    beats_sent++;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
      @(negedge clk_i);
      start     <= 1'b0;
      ordinal_i <= ORD_W'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Stop issuing, wait for every outstanding descriptor, then let the pipe empty.
  task automatic drain_pipeline();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_descriptors.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_register(input reg_e idx, input logic [DATA_W-1:0] value);
    drain_pipeline();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_BUILD_ENABLED:   cfg_build = value[0];
      REG_PROMPT_TOKENS:   cfg_prompt = value[TOK_W-1:0];
      REG_HIDDEN_CAPACITY: cfg_capacity = value[TOK_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pwdata  <= $urandom;
  endtask

  task automatic read_register(input reg_e idx);
    logic [DATA_W-1:0] want;
    logic [DATA_W-1:0] got;
    case (idx)
      REG_BUILD_ENABLED:   want = DATA_W'(cfg_build);
      REG_PROMPT_TOKENS:   want = DATA_W'(cfg_prompt);
      default:             want = DATA_W'(cfg_capacity);
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // Compare only the register's own bits.
    got = (idx == REG_BUILD_ENABLED) ? (prdata & 32'h1) : (prdata & 32'hFFFF);
    if (got != want) begin
      if (mismatch_count < 10)
        $display("%0t: register %s reads %0d, expected %0d", $realtime, idx.name(),
                 got, want);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write all three registers; random junk rides in the unused upper bits.
  task automatic apply_setting(input logic build, input logic [TOK_W-1:0] prompt,
                               input logic [TOK_W-1:0] capacity);
    write_register(REG_BUILD_ENABLED, {31'($urandom), build});
    write_register(REG_PROMPT_TOKENS, {16'($urandom), prompt});
    write_register(REG_HIDDEN_CAPACITY, {16'($urandom), capacity});
    settings_used++;
  endtask

  // Reset values: enabled but no prompt, so every ordinal reports a zero prompt.
  task automatic test_reset_state();
    read_register(REG_BUILD_ENABLED);
    read_register(REG_PROMPT_TOKENS);
    read_register(REG_HIDDEN_CAPACITY);
    send_ordinal('0);
    send_ordinal('1);
  endtask

  // The configuration checks, each ahead of the next in priority.
  task automatic test_setting_errors();
    apply_setting(1'b0, 16'd1000, 16'd1000);
    read_register(REG_BUILD_ENABLED);
    send_ordinal(12'd0);
    apply_setting(1'b0, 16'd0, 16'd0);
    send_ordinal(12'd5);
    apply_setting(1'b1, 16'd0, 16'd100);
    send_ordinal(12'd0);
    apply_setting(1'b1, 16'hFFFF, 16'hFFFF);
    read_register(REG_PROMPT_TOKENS);
    read_register(REG_HIDDEN_CAPACITY);
    send_ordinal(12'd0);
    apply_setting(1'b1, 16'd100, 16'd99);
    send_ordinal(12'd1);
    apply_setting(1'b1, 16'd100, 16'd32769);
    send_ordinal(12'd2);
  endtask

  // Largest prompt: 64 tiles, 3072 items; hit both ends and just past the range.
  task automatic test_full_prompt();
    apply_setting(1'b1, 16'd32768, 16'd32768);
    send_ordinal(12'd0);
    send_ordinal(12'd63);
    send_ordinal(12'd64);
    send_ordinal(12'd3071);
    send_ordinal(12'd3072);
    send_ordinal(12'd4095);
  endtask

  // One-token prompt, then a prompt one past a tile with its one-token tail.
  task automatic test_short_prompts();
    apply_setting(1'b1, 16'd1, 16'd1);
    send_ordinal(12'd0);
    send_ordinal(12'd3);
    send_ordinal(12'd47);
    send_ordinal(12'd48);
    apply_setting(1'b1, 16'd513, 16'd600);
    send_ordinal(12'd1);
    send_ordinal(12'd7);
    send_ordinal(12'd95);
    send_ordinal(12'd96);
  endtask

  // Random settings, mostly legal ones with ordinals in range, idling by phase.
  task automatic test_random_traffic();
    int unsigned         idle_phase[3] = '{0, 59, 14};
    int unsigned         total;
    int unsigned         pick;
    logic [TOK_W-1:0]    prompt;
    logic [TOK_W-1:0]    capacity;
    for (int b = 0; b < BURSTS; b++) begin
      sender_idle_pct = idle_phase[b % 3];
      pick = $urandom_range(9);
      case (pick)
        0: apply_setting(1'b0, 16'($urandom), 16'($urandom));
        1: apply_setting(1'b1, 16'd0, 16'($urandom));
        2: begin
          case ($urandom_range(2))
            0: apply_setting(1'b1, 16'($urandom_range(32769, 65535)), 16'($urandom));
            1: begin
              prompt = 16'($urandom_range(2, 32768));
              apply_setting(1'b1, prompt, 16'($urandom_range(1, prompt - 1)));
            end
            default: apply_setting(1'b1, 16'($urandom_range(1, 32768)),
                                   16'($urandom_range(32769, 65535)));
          endcase
        end
        default: begin
          case ($urandom_range(7))
            0: prompt = 16'd1;
            1: prompt = 16'(TILE_TOKENS * $urandom_range(1, 64));
            2: prompt = 16'(TILE_TOKENS * $urandom_range(1, 63) + 1);
            3: prompt = 16'd32767;
            default: prompt = 16'($urandom_range(1, 32768));
          endcase
          capacity = ($urandom_range(3) == 0) ? 16'd32768 : prompt;
          if ($urandom_range(1) == 0) capacity = 16'($urandom_range(prompt, 32768));
          apply_setting(1'b1, prompt, capacity);
        end
      endcase
      total = decode_work_item('0).total_items;
      for (int k = 0; k < BURST_BEATS; k++) begin
        if (total != 0 && $urandom_range(99) < 85)
          send_ordinal(ORD_W'($urandom_range(total - 1)));
        else
          send_ordinal(ORD_W'($urandom));
      end
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_state();
    test_setting_errors();
    test_full_prompt();
    test_short_prompts();
    test_random_traffic();
    drain_pipeline();
    $display("Sent %0d ordinals under %0d register settings; %0d valid and %0d error",
             beats_sent, settings_used, descriptors_ok, descriptors_err);
    $display("descriptors checked, %0d mismatches.", mismatch_count);
    if (mismatch_count == 0 && pending_descriptors.size() == 0) begin
      $display("layer_tile_work_item_decoder_test OK");
    end else begin
      $display("layer_tile_work_item_decoder_test NOT OK");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Run timed out with %0d descriptors outstanding", pending_descriptors.size());
    $display("layer_tile_work_item_decoder_test NOT OK");
    $finish;
  end

endmodule
